// File: hdl/ice_pkg.sv
// shared types, command codes and one's-complement helpers for the internet checksum engine
// no dependencies
package ice_pkg;

	localparam logic [1:0] CMD_DATA   = 2'd0;
	localparam logic [1:0] CMD_PSEUDO = 2'd1;
	localparam logic [1:0] CMD_INCR   = 2'd2;

	localparam logic ORIGIN_PACKET = 1'b0;
	localparam logic ORIGIN_INCR   = 1'b1;

	localparam logic [15:0] MASK16 = 16'hffff;

	// wide enough for up to eight 16-bit terms
	localparam int SUM_W = 19;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  protocol;
		logic [15:0] l4_length;
		logic [15:0] stored_check;
		logic [15:0] prev_word;
		logic [15:0] repl_word;
	} item_t;

	typedef struct packed {
		logic [15:0] checksum;
		logic        origin_kind;
	} result_t;

	// end-around fold of a multi-term sum, two passes bring it under 17 bits
	function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		begin
			f1 = {1'b0, s[15:0]} + {14'd0, s[SUM_W-1:16]};
			f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
			return f2[15:0];
		end
	endfunction

	function automatic logic [SUM_W-1:0] widen(input logic [15:0] v);
		return {{(SUM_W-16){1'b0}}, v};
	endfunction

endpackage

// File: hdl/ice_in_reg.sv
// input register stage of the internet checksum engine
// depends on ice_pkg for the item type
module ice_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  ice_pkg::item_t item,
	input  logic          adv,
	output logic          stall,
	output logic          valid_s1,
	output ice_pkg::item_t item_s1
);

	logic load;

	// holds only while the stage cannot retire its item
	assign stall = valid_s1 && !adv;
	assign load  = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// File: hdl/ice_sum_unit.sv
// running one's-complement sum, byte pairing and result formation
// depends on ice_pkg for types, command codes and the fold function
module ice_sum_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  ice_pkg::item_t  item_s1,
	input  logic            out_free,
	output logic            adv,
	output logic            res_valid,
	output ice_pkg::result_t result
);

	logic [15:0] running_sum_q;
	logic [7:0]  held_high_byte_q;
	logic        byte_pending_q;

	logic [15:0] data_word;
	logic [15:0] data_sum;
	logic [15:0] pseudo_sum;
	logic [15:0] incr_sum;
	logic        emit;

	logic [15:0] sum_nxt;
	logic [7:0]  held_nxt;
	logic        pending_nxt;

	// odd trailing byte goes in as the high byte with a zero low byte
	assign data_word = byte_pending_q ? {held_high_byte_q, item_s1.data_byte}
	                                  : {item_s1.data_byte, 8'h00};

	assign data_sum = ice_pkg::fold_sum(ice_pkg::widen(running_sum_q)
		+ ice_pkg::widen(data_word));

	assign pseudo_sum = ice_pkg::fold_sum(ice_pkg::widen(running_sum_q)
		+ ice_pkg::widen(item_s1.src_addr[31:16])
		+ ice_pkg::widen(item_s1.src_addr[15:0])
		+ ice_pkg::widen(item_s1.dst_addr[31:16])
		+ ice_pkg::widen(item_s1.dst_addr[15:0])
		+ ice_pkg::widen({8'h00, item_s1.protocol})
		+ ice_pkg::widen(item_s1.l4_length));

	assign incr_sum = ice_pkg::fold_sum(ice_pkg::widen(~item_s1.stored_check)
		+ ice_pkg::widen(~item_s1.prev_word)
		+ ice_pkg::widen(item_s1.repl_word));

	always_comb begin
		sum_nxt            = running_sum_q;
		held_nxt           = held_high_byte_q;
		pending_nxt        = byte_pending_q;
		emit               = 1'b0;
		result.checksum    = ~data_sum;
		result.origin_kind = ice_pkg::ORIGIN_PACKET;
		unique case (item_s1.command)
			ice_pkg::CMD_DATA: begin
				if (item_s1.last) begin
					emit        = 1'b1;
					sum_nxt     = '0;
					held_nxt    = '0;
					pending_nxt = 1'b0;
				end else if (byte_pending_q) begin
					sum_nxt     = data_sum;
					held_nxt    = '0;
					pending_nxt = 1'b0;
				end else begin
					held_nxt    = item_s1.data_byte;
					pending_nxt = 1'b1;
				end
			end
			ice_pkg::CMD_PSEUDO: begin
				sum_nxt = pseudo_sum;
			end
			ice_pkg::CMD_INCR: begin
				emit               = 1'b1;
				result.checksum    = ~incr_sum;
				result.origin_kind = ice_pkg::ORIGIN_INCR;
			end
			default: begin
			end
		endcase
	end

	assign adv       = valid_s1 && (!emit || out_free);
	assign res_valid = adv && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q    <= '0;
			held_high_byte_q <= '0;
			byte_pending_q   <= 1'b0;
		end else if (adv) begin
			running_sum_q    <= sum_nxt;
			held_high_byte_q <= held_nxt;
			byte_pending_q   <= pending_nxt;
		end
	end

endmodule

// File: hdl/ice_out_reg.sv
// result register of the internet checksum engine
// depends on ice_pkg for the result type
module ice_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  ice_pkg::result_t result,
	input  logic             stall,
	output logic             out_free,
	output logic             valid,
	output ice_pkg::result_t result_q
);

	assign out_free = !valid || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (out_free) begin
			valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			result_q <= result;
		end
	end

endmodule

// File: hdl/internet_checksum_engine_top.sv
// top level of the internet checksum engine (rfc 1071 sum, pseudo-header, rfc 1624 update)
// depends on ice_pkg, ice_in_reg, ice_sum_unit and ice_out_reg
//
// usage
//   command channel: cmd_valid / cmd_stall with one field per port; an item is taken
//     at a rising edge where cmd_valid is high and cmd_stall is low
//   command 0 streams packet bytes in wire order, paired big-endian into words;
//     the byte with last set closes the packet and yields its checksum
//   command 1 folds an ipv4 pseudo-header into the running sum, no result
//   command 2 yields the incremental update of a checksum at once, state untouched
//   command 3 is dropped without effect
//   result channel: sum_valid / sum_stall carrying checksum and origin_kind
//   a taken item is held in the input register, and its result is then registered in
//     the result register unless a full, stalled result register holds it back
//   throughput: one item per cycle while the input stage is not stalled, set by the
//     combinational end-around adder between the input register and the result register
//   a stalled result holds; the input stage keeps taking items that produce no
//     result, and stalls only when an item with a result meets a full, stalled
//     result register
//   reset clears the running sum, the held byte and both valid flags
module internet_checksum_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [7:0]  protocol,
	input  logic [15:0] l4_length,
	input  logic [15:0] stored_check,
	input  logic [15:0] prev_word,
	input  logic [15:0] repl_word,
	output logic        sum_valid,
	input  logic        sum_stall,
	output logic [15:0] checksum,
	output logic        origin_kind
);

	ice_pkg::item_t   item;
	ice_pkg::item_t   item_s1;
	ice_pkg::result_t result;
	ice_pkg::result_t result_s2;
	logic             valid_s1;
	logic             adv;
	logic             res_valid;
	logic             out_free;

	// gather the command fields into one item word
	always_comb begin
		item.command      = command;
		item.data_byte    = data_byte;
		item.last         = last;
		item.src_addr     = src_addr;
		item.dst_addr     = dst_addr;
		item.protocol     = protocol;
		item.l4_length    = l4_length;
		item.stored_check = stored_check;
		item.prev_word    = prev_word;
		item.repl_word    = repl_word;
	end

	// stage 1: input register
	ice_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (cmd_valid),
		.item     (item),
		.adv      (adv),
		.stall    (cmd_stall),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// running sum state and the combinational adder
	ice_sum_unit u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.adv       (adv),
		.res_valid (res_valid),
		.result    (result)
	);

	// stage 2: result register
	ice_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.result    (result),
		.stall     (sum_stall),
		.out_free  (out_free),
		.valid     (sum_valid),
		.result_q  (result_s2)
	);

	assign checksum    = result_s2.checksum;
	assign origin_kind = result_s2.origin_kind;

endmodule

// File: hdl/ice_checker.sv
// port-level assertions for the internet checksum engine, bound to the top level
// depends on ice_pkg for command and origin codes
module ice_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic [1:0]  command,
	input logic        sum_valid,
	input logic        sum_stall,
	input logic [15:0] checksum,
	input logic        origin_kind
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> $stable(checksum) && $stable(origin_kind))
		else $error("result payload changed while stalled");

	// the input side only backs up behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> sum_valid && sum_stall)
		else $error("command stall without a stalled result");

	// an incremental update passes from the input register into the result register when not held up
	a_incr_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && command == ice_pkg::CMD_INCR ##1 !sum_stall
		|=> sum_valid && origin_kind == ice_pkg::ORIGIN_INCR)
		else $error("incremental update result missing");

endmodule

bind internet_checksum_engine_top ice_checker u_chk (.*);
